>>> sv/chwm_pkg.sv
// Shared types, constants and helper functions of the circular heading window mean unit.
package chwm_pkg;

    // Datapath width of the shared CORDIC unit. Sized for the largest window (256 entries):
    // a sum of 2^23 scaled by 2^20 and grown by the vectoring gain still fits.
    localparam int CW       = 48;
    // Angle accumulator width; angles are binary, 2^32 per turn, two guard bits.
    localparam int ZW       = 34;
    localparam int ITERS    = 16;
    localparam int ITER_W   = 4;
    localparam int HEAD_W   = 16;
    localparam int Q15_W    = 16;
    localparam int ANG_FULL = 36000;

    typedef logic signed [CW-1:0]    cval_t;
    typedef logic signed [ZW-1:0]    zval_t;
    typedef logic signed [Q15_W-1:0] q15_t;
    typedef logic [ITER_W-1:0]       iter_t;

    typedef struct packed {
        logic start;
        logic rot;
    } cordic_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_sts_t;

    // Arctangent of 2^-i as a binary angle, 2^32 per turn.
    function automatic logic [31:0] atan_lut(input iter_t idx);
        logic [31:0] a;
        case (idx)
            4'd0:    a = 32'h2000_0000;
            4'd1:    a = 32'h12E4_051E;
            4'd2:    a = 32'h09FB_385B;
            4'd3:    a = 32'h0511_11D4;
            4'd4:    a = 32'h028B_0D43;
            4'd5:    a = 32'h0145_D7E1;
            4'd6:    a = 32'h00A2_F61E;
            4'd7:    a = 32'h0051_7C55;
            4'd8:    a = 32'h0028_BE53;
            4'd9:    a = 32'h0014_5F2F;
            4'd10:   a = 32'h000A_2F98;
            4'd11:   a = 32'h0005_17CC;
            4'd12:   a = 32'h0002_8BE6;
            4'd13:   a = 32'h0001_45F3;
            4'd14:   a = 32'h0000_A2FA;
            4'd15:   a = 32'h0000_517D;
            default: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

    // Rounds a value with unity at 2^30 to Q1.15 and saturates.
    function automatic q15_t to_q15(input cval_t v);
        cval_t t;
        q15_t  r;
        t = (v + cval_t'(16384)) >>> 15;
        if (t > cval_t'(32767)) begin
            r = 16'sh7FFF;
        end
        else if (t < -cval_t'(32768)) begin
            r = 16'sh8000;
        end
        else begin
            r = q15_t'(t);
        end
        return r;
    endfunction

endpackage

>>> sv/chwm_cordic.sv
// Shared CORDIC unit: one micro-rotation per cycle, in rotation or vectoring mode.
module chwm_cordic
    import chwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cordic_cmd_t cmd,
    input  cval_t       x_init,
    input  cval_t       y_init,
    input  zval_t       z_init,
    output cordic_sts_t sts,
    output cval_t       x_res,
    output cval_t       y_res,
    output zval_t       z_res
);

    cval_t x_reg, y_reg;
    zval_t z_reg;
    iter_t iter_reg;
    logic  busy_reg, done_reg, rot_reg;

    cval_t x_sh, y_sh, x_next, y_next;
    zval_t z_next, a_step;
    logic  ccw;

    // Both modes turn the vector anticlockwise under the same condition pattern, so one
    // adder set serves both; only the direction decision differs.
    always_comb
    begin
        x_sh   = x_reg >>> iter_reg;
        y_sh   = y_reg >>> iter_reg;
        a_step = zval_t'({2'b00, atan_lut(iter_reg)});
        ccw    = rot_reg ? !z_reg[ZW-1] : (y_reg[CW-1] || (y_reg == '0));
        if (ccw) begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - a_step;
        end
        else begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + a_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            rot_reg  <= 1'b0;
        end
        else if (cmd.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            iter_reg <= '0;
            rot_reg  <= cmd.rot;
        end
        else if (busy_reg) begin
            iter_reg <= iter_reg + iter_t'(1);
            if (iter_reg == iter_t'(ITERS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start) begin
            x_reg <= x_init;
            y_reg <= y_init;
            z_reg <= z_init;
        end
        else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign x_res    = x_reg;
    assign y_res    = y_reg;
    assign z_res    = z_reg;

endmodule

>>> sv/circular_heading_window_mean_unit.sv
// Top level of the circular heading window mean unit: sequencer, ring memory and sums.
//
//  Channel | Handshake             | Payload                        | Direction
//  --------+-----------------------+--------------------------------+----------
//  input   | in_valid / in_ready   | heading_in[15:0], in_invalid   | into block
//  output  | out_valid / out_ready | mean_heading[15:0]             | out of block
//
// A valid heading passes through the sequencer in order: the binary phase is formed, the
// shared CORDIC unit rotates, the unit vector is rounded and accumulated, the CORDIC unit
// vectors the sums, and the angle is converted and loaded; a zero summed vector skips vectoring.
// An invalid item goes from idle straight to the done state. in_ready is high only while idle,
// so an item is taken only once the last one has gone to the output; a result not yet taken holds
// the next one in the sequencer. Reset clears sums, slot and ring valid bits; ready at once.
module circular_heading_window_mean_unit
    import chwm_pkg::*;
#(
    parameter int WINDOW = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [HEAD_W-1:0]   heading_in,
    input  logic                in_invalid,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [HEAD_W-1:0]   mean_heading
);

    localparam int SLOT_W = $clog2(WINDOW);
    // Sum of WINDOW Q1.15 values, with a sign bit and one bit of headroom.
    localparam int SUM_W  = $clog2(WINDOW) + 17;
    localparam int MUL_W  = 49;

    // 36000 = 2^5 * 1125, so the phase h * 2^32 / 36000 is h * 2^27 / 1125. The reciprocal
    // below carries 16 fraction bits; for h under 2^16 the estimate is low by at most one.
    localparam logic [32:0] PH_RECIP = 33'((64'd1 << 43) / 64'd1125);
    localparam logic [10:0] PH_DIV   = 11'd1125;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL1   = 4'd1;
    localparam logic [3:0] S_MUL2   = 4'd2;
    localparam logic [3:0] S_PHASE  = 4'd3;
    localparam logic [3:0] S_ROT    = 4'd4;
    localparam logic [3:0] S_Q15    = 4'd5;
    localparam logic [3:0] S_ACC    = 4'd6;
    localparam logic [3:0] S_VSTART = 4'd7;
    localparam logic [3:0] S_VEC    = 4'd8;
    localparam logic [3:0] S_CONV1  = 4'd9;
    localparam logic [3:0] S_CONV2  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] state_reg, state_next;

    // Ring of unit vectors. Entries that have never been written read as zero through
    // their valid bit, which reset clears.
    q15_t ring_cos_mem [WINDOW];
    q15_t ring_sin_mem [WINDOW];
    logic [WINDOW-1:0] vld_reg;
    q15_t rd_cos_reg, rd_sin_reg;
    logic rd_vld_reg;

    logic [SLOT_W-1:0] slot_reg;
    logic signed [SUM_W-1:0] sum_cos_reg, sum_sin_reg;

    // Per-item working registers.
    logic [HEAD_W-1:0] h_reg;
    logic [MUL_W-1:0]  mul_reg;
    logic [31:0]       q_reg;
    logic              flip_reg;
    q15_t              c_reg, s_reg;
    logic [HEAD_W-1:0] res_reg;

    logic              out_valid_reg;
    logic [HEAD_W-1:0] out_data_reg;

    // Shared CORDIC unit.
    cordic_cmd_t cmd;
    cordic_sts_t sts;
    cval_t       x_init, y_init, x_res, y_res;
    zval_t       z_init, z_res;

    logic              accept;
    logic              out_load;
    logic [HEAD_W-1:0] h_wrapped;
    logic [42:0]       rem;
    logic [31:0]       ph_raw, ph_fold;
    logic              ph_flip;
    cval_t             xv, yv, sx_ext, sy_ext;
    logic signed [SUM_W-1:0] old_cos, old_sin;
    logic [MUL_W-1:0]  conv_sum;
    logic [HEAD_W-1:0] cd;
    logic              sums_zero;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        // A heading above the nominal range wraps once; 65535 is below 2 * 36000.
        if (heading_in >= HEAD_W'(ANG_FULL)) begin
            h_wrapped = heading_in - HEAD_W'(ANG_FULL);
        end
        else begin
            h_wrapped = heading_in;
        end

        // Remainder check lifts the reciprocal estimate to the exact floor.
        rem    = {h_reg, 27'b0} - mul_reg[42:0];
        ph_raw = (rem >= 43'(PH_DIV)) ? (q_reg + 32'd1) : q_reg;
        // Headings between 90 and 270 degrees are rotated by half a turn and the result
        // negated afterwards, which keeps the rotation inside the CORDIC's reach.
        ph_flip = (ph_raw[31:30] == 2'b01) || (ph_raw[31:30] == 2'b10);
        ph_fold = ph_flip ? (ph_raw ^ 32'h8000_0000) : ph_raw;

        xv = flip_reg ? -x_res : x_res;
        yv = flip_reg ? -y_res : y_res;

        old_cos = rd_vld_reg ? SUM_W'(rd_cos_reg) : '0;
        old_sin = rd_vld_reg ? SUM_W'(rd_sin_reg) : '0;

        sx_ext    = CW'(sum_cos_reg) <<< 20;
        sy_ext    = CW'(sum_sin_reg) <<< 20;
        sums_zero = (sum_cos_reg == '0) && (sum_sin_reg == '0);

        // Round the scaled angle to hundredths of a degree; a full turn folds to zero.
        conv_sum = mul_reg + MUL_W'(64'h8000_0000);
        cd       = conv_sum[47:32];

        cmd.start = 1'b0;
        cmd.rot   = 1'b0;
        x_init    = cval_t'(652032874);
        y_init    = '0;
        z_init    = zval_t'($signed(ph_fold));
        if (state_reg == S_PHASE) begin
            cmd.start = 1'b1;
            cmd.rot   = 1'b1;
        end
        else if ((state_reg == S_VSTART) && !sums_zero) begin
            cmd.start = 1'b1;
            // The left half-plane is mirrored and the angle starts at half a turn.
            if (sum_cos_reg[SUM_W-1]) begin
                x_init = -sx_ext;
                y_init = -sy_ext;
                z_init = zval_t'(34'h0_8000_0000);
            end
            else begin
                x_init = sx_ext;
                y_init = sy_ext;
                z_init = '0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    state_next = in_invalid ? S_DONE : S_MUL1;
                end
            end
            S_MUL1:   state_next = S_MUL2;
            S_MUL2:   state_next = S_PHASE;
            S_PHASE:  state_next = S_ROT;
            S_ROT:
            begin
                if (sts.done) begin
                    state_next = S_Q15;
                end
            end
            S_Q15:    state_next = S_ACC;
            S_ACC:    state_next = S_VSTART;
            S_VSTART: state_next = sums_zero ? S_DONE : S_VEC;
            S_VEC:
            begin
                if (sts.done) begin
                    state_next = S_CONV1;
                end
            end
            S_CONV1:  state_next = S_CONV2;
            S_CONV2:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    chwm_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .x_init (x_init),
        .y_init (y_init),
        .z_init (z_init),
        .sts    (sts),
        .x_res  (x_res),
        .y_res  (y_res),
        .z_res  (z_res)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            sum_cos_reg   <= '0;
            sum_sin_reg   <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (state_reg == S_ACC) begin
                sum_cos_reg       <= sum_cos_reg + SUM_W'(c_reg) - old_cos;
                sum_sin_reg       <= sum_sin_reg + SUM_W'(s_reg) - old_sin;
                vld_reg[slot_reg] <= 1'b1;
                if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                    slot_reg <= '0;
                end
                else begin
                    slot_reg <= slot_reg + SLOT_W'(1);
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Ring memory: one read and one write port, read data registered.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL1) begin
            rd_cos_reg <= ring_cos_mem[slot_reg];
            rd_sin_reg <= ring_sin_mem[slot_reg];
            rd_vld_reg <= vld_reg[slot_reg];
        end
        if (state_reg == S_ACC) begin
            ring_cos_mem[slot_reg] <= c_reg;
            ring_sin_mem[slot_reg] <= s_reg;
        end
    end

    // Working registers along the sequence.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                h_reg   <= h_wrapped;
                res_reg <= '0;
            end
            S_MUL1:   mul_reg <= MUL_W'(h_reg) * MUL_W'(PH_RECIP);
            S_MUL2:
            begin
                q_reg   <= mul_reg[47:16];
                mul_reg <= MUL_W'(mul_reg[47:16]) * MUL_W'(PH_DIV);
            end
            S_PHASE:  flip_reg <= ph_flip;
            S_Q15:
            begin
                c_reg <= to_q15(xv);
                s_reg <= to_q15(yv);
            end
            S_VSTART: res_reg <= '0;
            S_CONV1:  mul_reg <= MUL_W'(z_res[31:0]) * MUL_W'(ANG_FULL);
            S_CONV2:  res_reg <= (cd >= HEAD_W'(ANG_FULL)) ? '0 : cd;
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
        if (out_load) begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mean_heading = out_data_reg;

`ifndef SYNTH
    // An invalid item must leave the running sums alone.
    a_invalid_keeps_sums: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_invalid |=> $stable(sum_cos_reg) && $stable(sum_sin_reg))
        else $error("invalid item changed the running sums");

    // The CORDIC unit is never restarted while it is still iterating.
    a_cordic_free_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !sts.busy)
        else $error("CORDIC started while busy");

    // The sums always lie within the range of a sum of WINDOW Q1.15 entries.
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_cos_reg <= WINDOW * 32767) && (sum_cos_reg >= -(WINDOW * 32768)) &&
        (sum_sin_reg <= WINDOW * 32767) && (sum_sin_reg >= -(WINDOW * 32768)))
        else $error("running sum out of range");

    // A delivered mean heading lies below a full turn.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mean_heading < HEAD_W'(ANG_FULL)))
        else $error("mean heading out of range");
`endif

endmodule
